FILE: hw/rtl/mpps_pkg.sv
package mpps_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int TIME_W       = 32;
    localparam int SLICE_W      = 16;
    localparam int CNT_W        = 5;
    localparam int FIELD_IDX_W  = 4;
    localparam int WORD_W       = 2 * TIME_W;
    localparam int CFG_DATA_W   = 16;

    localparam logic [SLICE_W-1:0] QUANTUM_RST   = SLICE_W'(500);
    localparam logic [CNT_W-1:0]   JOB_COUNT_RST = CNT_W'(1);
    localparam logic [SLICE_W-1:0] SLICE_MAX     = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX      = '1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        CFG_POLICY    = 2'd0,
        CFG_JOB_COUNT = 2'd1,
        CFG_QUANTUM   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_RR   = 2'd1,
        POL_SJF  = 2'd2,
        POL_PSJF = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FETCH,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic ff_found;
        logic ff_one;
        logic sj_found;
        logic sj_one;
        logic rr_any;
        logic rr_one;
        logic rr_gt;
        logic rr_gone;
        logic cur_zero;
        logic cur_one;
    } scan_flags_t;

endpackage

FILE: hw/rtl/multi_policy_process_scheduler_top.sv
// Channel  | Direction | Handshake          | Content
// s_*      | in        | s_tvalid/s_tready  | job load or tick; tuser selects which
// m_*      | out       | m_tvalid/m_tready  | one result per tick, none per load
// cfg_*    | in        | cfg_valid/cfg_ready| register index and write data
//
// A load is written to job memory as it is taken. A tick scans n entries, n being
// min(job_count, MAX_JOBS), and skips the scan when n is zero: the scan reads one entry per
// cycle, then decide, and fetch and write back the chosen entry when a job is chosen.
// Reset returns control and configuration registers to their defaults; job memory contents are undefined until loaded.
// The input is taken only in idle; a result that waits on m_tready stalls the next
// tick in its final cycle only.
module multi_policy_process_scheduler_top #(
    parameter int MAX_JOBS = mpps_pkg::MAX_JOBS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // entry_index[3:0], arrival_tick[35:4], run_time[67:36]
    input  logic        s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // running_index[3:0], running_valid[4], switched[5],
                                   // finished_valid[6], finished_index[10:7], all_done[11]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW    = $clog2(MAX_JOBS);
    localparam int CW    = mpps_pkg::CNT_W;
    localparam int TW    = mpps_pkg::TIME_W;
    localparam int SW    = mpps_pkg::SLICE_W;
    localparam int FW    = mpps_pkg::FIELD_IDX_W;
    localparam int NCAP  = (MAX_JOBS < 31) ? MAX_JOBS : 31;

    mpps_pkg::state_t  state_reg, state_next;
    mpps_pkg::policy_t policy_reg, policy_next;
    logic [CW-1:0]     job_count_reg, job_count_next;
    logic [SW-1:0]     quantum_reg, quantum_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic              act_reg, act_next;
    logic [SW-1:0]     slice_reg, slice_next;
    logic [TW-1:0]     now_reg, now_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              rv_reg, rv_next;
    logic [IW-1:0]     ridx_reg, ridx_next;
    logic [15:0]       res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_data_reg, out_data_next;

    logic [CW-1:0]     n_eff;
    logic [IW+CW-1:0]  cur_w;
    logic [IW+CW-1:0]  n_w;
    logic [IW+CW-1:0]  iss_w;
    logic [IW-1:0]     slot;
    logic              in_xfer;
    logic              tick_xfer;
    logic              load_xfer;
    logic              out_free;

    logic                          ram_we;
    logic [IW-1:0]                 ram_wr_addr;
    logic [mpps_pkg::WORD_W-1:0]   ram_wr_data;
    logic                          ram_rd_en;
    logic [IW-1:0]                 ram_rd_addr;
    logic [mpps_pkg::WORD_W-1:0]   ram_rd_data;
    logic [TW-1:0]                 rd_arr;
    logic [TW-1:0]                 rd_rem;

    logic                  scan_start;
    mpps_pkg::scan_flags_t flags;
    logic [IW-1:0]         ff_idx;
    logic [IW-1:0]         sj_idx;
    logic [IW-1:0]         rr_idx;
    logic [IW-1:0]         rr_gidx;
    logic [CW-1:0]         live;

    logic              retired;
    logic              act2;
    logic [SW-1:0]     slice1;
    logic [SW-1:0]     slice2;
    logic              found;
    logic [IW-1:0]     pidx;
    logic              pone;
    logic [CW-1:0]     live_f;
    logic [IW+FW-1:0]  pidx_w;
    logic [IW+FW-1:0]  curf_w;

    assign n_eff     = (job_count_reg > CW'(NCAP)) ? CW'(NCAP) : job_count_reg;
    assign cur_w     = {{CW{1'b0}}, cur_reg};
    assign n_w       = {{IW{1'b0}}, n_eff};
    assign iss_w     = {{IW{1'b0}}, iss_reg};
    assign pidx_w    = {{FW{1'b0}}, pidx};
    assign curf_w    = {{FW{1'b0}}, cur_reg};
    assign in_xfer   = s_tvalid && s_tready;
    assign tick_xfer = in_xfer && (s_tuser == mpps_pkg::MODE_TICK);
    assign load_xfer = in_xfer && (s_tuser == mpps_pkg::MODE_LOAD);
    assign out_free  = !out_valid_reg || m_tready;
    assign rd_arr    = ram_rd_data[TW-1:0];
    assign rd_rem    = ram_rd_data[2*TW-1:TW];

    always_comb
    begin
        slot = '0;
        for (int v = 0; v < 16; v++)
        begin
            if (s_tdata[FW-1:0] == FW'(v))
            begin
                slot = IW'(v % MAX_JOBS);
            end
        end
    end

    mpps_ram #(
        .WIDTH (mpps_pkg::WORD_W),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mpps_scan #(
        .MAX_JOBS (MAX_JOBS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .en      (rv_reg),
        .idx     (ridx_reg),
        .arr     (rd_arr),
        .rem     (rd_rem),
        .now     (now_reg),
        .cur     (cur_reg),
        .flags   (flags),
        .ff_idx  (ff_idx),
        .sj_idx  (sj_idx),
        .rr_idx  (rr_idx),
        .rr_gidx (rr_gidx),
        .live    (live)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpps_pkg::ST_IDLE:
            begin
                if (tick_xfer)
                begin
                    state_next = (n_eff == '0) ? mpps_pkg::ST_DECIDE : mpps_pkg::ST_SCAN;
                end
            end
            mpps_pkg::ST_SCAN:
            begin
                if (iss_reg == n_eff)
                begin
                    state_next = mpps_pkg::ST_DECIDE;
                end
            end
            mpps_pkg::ST_DECIDE:
            begin
                state_next = found ? mpps_pkg::ST_FETCH : mpps_pkg::ST_EMIT;
            end
            mpps_pkg::ST_FETCH:
            begin
                state_next = mpps_pkg::ST_UPDATE;
            end
            mpps_pkg::ST_UPDATE:
            begin
                state_next = mpps_pkg::ST_EMIT;
            end
            mpps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mpps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpps_pkg::ST_IDLE;
            end
        endcase
    end

    // memory and scan control
    always_comb
    begin
        s_tready    = 1'b0;
        scan_start  = 1'b0;
        ram_we      = 1'b0;
        ram_wr_addr = slot;
        ram_wr_data = {s_tdata[67:36], s_tdata[35:4]};
        ram_rd_en   = 1'b0;
        ram_rd_addr = iss_w[IW-1:0];
        unique case (state_reg)
            mpps_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                scan_start = tick_xfer;
                ram_we     = load_xfer;
            end
            mpps_pkg::ST_SCAN:
            begin
                ram_rd_en = iss_reg < n_eff;
            end
            mpps_pkg::ST_FETCH:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = cur_reg;
            end
            mpps_pkg::ST_UPDATE:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = cur_reg;
                ram_wr_data = {(rd_rem != '0) ? rd_rem - TW'(1) : rd_rem, rd_arr};
            end
            mpps_pkg::ST_DECIDE, mpps_pkg::ST_EMIT:
            begin
                ram_rd_en = 1'b0;
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // selection
    always_comb
    begin
        retired = act_reg && flags.cur_zero;
        act2    = act_reg && !retired;
        slice1  = retired ? '0 : slice_reg;
        found   = 1'b0;
        pidx    = cur_reg;
        pone    = flags.cur_one;
        case (policy_reg)
            mpps_pkg::POL_FIFO:
            begin
                if (act2)
                begin
                    found = 1'b1;
                end
                else
                begin
                    found = flags.ff_found;
                    pidx  = ff_idx;
                    pone  = flags.ff_one;
                end
            end
            mpps_pkg::POL_RR:
            begin
                if (act2 && (slice1 < quantum_reg))
                begin
                    found = 1'b1;
                end
                else if (act2 && flags.rr_gt)
                begin
                    found = 1'b1;
                    pidx  = rr_gidx;
                    pone  = flags.rr_gone;
                end
                else
                begin
                    found = flags.rr_any;
                    pidx  = rr_idx;
                    pone  = flags.rr_one;
                end
            end
            mpps_pkg::POL_SJF:
            begin
                if (act2)
                begin
                    found = 1'b1;
                end
                else
                begin
                    found = flags.sj_found;
                    pidx  = sj_idx;
                    pone  = flags.sj_one;
                end
            end
            default:
            begin
                found = flags.sj_found;
                pidx  = sj_idx;
                pone  = flags.sj_one;
            end
        endcase
        if (n_eff == '0)
        begin
            found = 1'b0;
        end
        slice2 = (slice1 >= quantum_reg) ? '0 : slice1;
        if (found && (slice2 != mpps_pkg::SLICE_MAX))
        begin
            slice2 = slice2 + SW'(1);
        end
        live_f = live - CW'(found && pone);
    end

    // datapath registers
    always_comb
    begin
        policy_next    = policy_reg;
        job_count_next = job_count_reg;
        quantum_next   = quantum_reg;
        cur_next       = cur_reg;
        act_next       = act_reg;
        slice_next     = slice_reg;
        now_next       = now_reg;
        iss_next       = iss_reg;
        rv_next        = ram_rd_en && (state_reg == mpps_pkg::ST_SCAN);
        ridx_next      = iss_w[IW-1:0];
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mpps_pkg::CFG_POLICY:    policy_next    = mpps_pkg::policy_t'(cfg_data[1:0]);
                mpps_pkg::CFG_JOB_COUNT: job_count_next = cfg_data[CW-1:0];
                mpps_pkg::CFG_QUANTUM:   quantum_next   = cfg_data[SW-1:0];
                default:                 quantum_next   = quantum_reg;
            endcase
        end

        unique case (state_reg)
            mpps_pkg::ST_IDLE:
            begin
                iss_next = '0;
                if (tick_xfer && act_reg && !(cur_w < n_w))
                begin
                    act_next   = 1'b0;
                    slice_next = '0;
                end
            end
            mpps_pkg::ST_SCAN:
            begin
                if (ram_rd_en)
                begin
                    iss_next = iss_reg + CW'(1);
                end
            end
            mpps_pkg::ST_DECIDE:
            begin
                cur_next   = found ? pidx : cur_reg;
                act_next   = found;
                slice_next = slice2;
                now_next   = (now_reg != mpps_pkg::TIME_MAX) ? now_reg + TW'(1) : now_reg;
                res_next   = {4'b0000,
                              live_f == '0,
                              retired ? curf_w[FW-1:0] : {FW{1'b0}},
                              retired,
                              found && (!act2 || (pidx != cur_reg)),
                              found,
                              found ? pidx_w[FW-1:0] : {FW{1'b0}}};
            end
            mpps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            mpps_pkg::ST_FETCH, mpps_pkg::ST_UPDATE:
            begin
                iss_next = iss_reg;
            end
            default:
            begin
                iss_next = iss_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpps_pkg::ST_IDLE;
            policy_reg    <= mpps_pkg::POL_FIFO;
            job_count_reg <= mpps_pkg::JOB_COUNT_RST;
            quantum_reg   <= mpps_pkg::QUANTUM_RST;
            cur_reg       <= '0;
            act_reg       <= 1'b0;
            slice_reg     <= '0;
            now_reg       <= '0;
            iss_reg       <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            job_count_reg <= job_count_next;
            quantum_reg   <= quantum_next;
            cur_reg       <= cur_next;
            act_reg       <= act_next;
            slice_reg     <= slice_next;
            now_reg       <= now_next;
            iss_reg       <= iss_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg     <= ridx_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpps_pkg::ST_SCAN && ram_rd_en) |-> (iss_reg < n_eff))
        else $error("scan read beyond job count");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == mpps_pkg::ST_IDLE || state_reg == mpps_pkg::ST_UPDATE))
        else $error("job memory written during scan");

    a_fetch_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpps_pkg::ST_FETCH) |-> (act_reg && $past(state_reg) == mpps_pkg::ST_DECIDE))
        else $error("fetch without a chosen job");

    a_retire_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpps_pkg::ST_EMIT && res_reg[6] && res_reg[4] && MAX_JOBS <= 16)
            |-> (res_reg[10:7] != res_reg[3:0]))
        else $error("retired job chosen again");

endmodule

FILE: hw/rtl/mpps_ram.sv
module mpps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mpps_scan.sv
module mpps_scan #(
    parameter int MAX_JOBS = mpps_pkg::MAX_JOBS_DEF,
    localparam int IW = $clog2(MAX_JOBS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              en,
    input  logic [IW-1:0]                     idx,
    input  logic [mpps_pkg::TIME_W-1:0]       arr,
    input  logic [mpps_pkg::TIME_W-1:0]       rem,
    input  logic [mpps_pkg::TIME_W-1:0]       now,
    input  logic [IW-1:0]                     cur,
    output mpps_pkg::scan_flags_t             flags,
    output logic [IW-1:0]                     ff_idx,
    output logic [IW-1:0]                     sj_idx,
    output logic [IW-1:0]                     rr_idx,
    output logic [IW-1:0]                     rr_gidx,
    output logic [mpps_pkg::CNT_W-1:0]        live
);

    mpps_pkg::scan_flags_t             flags_reg, flags_next;
    logic                              prefix_reg, prefix_next;
    logic [IW-1:0]                     ff_idx_reg, ff_idx_next;
    logic [IW-1:0]                     sj_idx_reg, sj_idx_next;
    logic [IW-1:0]                     rr_idx_reg, rr_idx_next;
    logic [IW-1:0]                     rr_gidx_reg, rr_gidx_next;
    logic [mpps_pkg::TIME_W-1:0]       sj_rem_reg, sj_rem_next;
    logic [mpps_pkg::CNT_W-1:0]        live_reg, live_next;

    logic arrived;
    logic pos;
    logic is_one;
    logic elig;
    logic rdy;

    assign arrived = now >= arr;
    assign pos     = rem != '0;
    assign is_one  = rem == mpps_pkg::TIME_W'(1);
    assign elig    = prefix_reg && arrived && pos;
    assign rdy     = arrived && pos;

    always_comb
    begin
        flags_next   = flags_reg;
        prefix_next  = prefix_reg;
        ff_idx_next  = ff_idx_reg;
        sj_idx_next  = sj_idx_reg;
        rr_idx_next  = rr_idx_reg;
        rr_gidx_next = rr_gidx_reg;
        sj_rem_next  = sj_rem_reg;
        live_next    = live_reg;
        if (start)
        begin
            flags_next  = '0;
            prefix_next = 1'b1;
            live_next   = '0;
        end
        else if (en)
        begin
            prefix_next = prefix_reg && arrived;
            if (elig && !flags_reg.ff_found)
            begin
                flags_next.ff_found = 1'b1;
                flags_next.ff_one   = is_one;
                ff_idx_next         = idx;
            end
            if (elig && (!flags_reg.sj_found || rem < sj_rem_reg))
            begin
                flags_next.sj_found = 1'b1;
                flags_next.sj_one   = is_one;
                sj_idx_next         = idx;
                sj_rem_next         = rem;
            end
            if (rdy && !flags_reg.rr_any)
            begin
                flags_next.rr_any = 1'b1;
                flags_next.rr_one = is_one;
                rr_idx_next       = idx;
            end
            if (rdy && (idx > cur) && !flags_reg.rr_gt)
            begin
                flags_next.rr_gt   = 1'b1;
                flags_next.rr_gone = is_one;
                rr_gidx_next       = idx;
            end
            if (idx == cur)
            begin
                flags_next.cur_zero = !pos;
                flags_next.cur_one  = is_one;
            end
            if (pos)
            begin
                live_next = live_reg + mpps_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            prefix_reg <= 1'b1;
            live_reg   <= '0;
        end
        else
        begin
            flags_reg  <= flags_next;
            prefix_reg <= prefix_next;
            live_reg   <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ff_idx_reg  <= ff_idx_next;
        sj_idx_reg  <= sj_idx_next;
        rr_idx_reg  <= rr_idx_next;
        rr_gidx_reg <= rr_gidx_next;
        sj_rem_reg  <= sj_rem_next;
    end

    assign flags   = flags_reg;
    assign ff_idx  = ff_idx_reg;
    assign sj_idx  = sj_idx_reg;
    assign rr_idx  = rr_idx_reg;
    assign rr_gidx = rr_gidx_reg;
    assign live    = live_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS       = 16;
    localparam int DRAIN_WAIT  = SLOTS + 14;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 150;
    localparam int TICK_CAP    = 80;

    typedef struct packed {
        logic       all_done;
        logic [3:0] finished_index;
        logic       finished_valid;
        logic       switched;
        logic       running_valid;
        logic [3:0] running_index;
    } sched_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_TICK
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        mpps_pkg::cfg_index_t reg_idx;
        logic [15:0]          word;
        logic [3:0]           slot;
        logic [31:0]          arrive;
        logic [31:0]          run;
        logic                 typed;
        sched_result_t        want;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // scheduler state as predicted
    logic [31:0]       arrival_q [SLOTS];
    logic [31:0]       remaining_q [SLOTS];
    logic [3:0]        cur_job     = '0;
    logic              job_busy    = 1'b0;
    logic [15:0]       slice_used  = '0;
    logic [31:0]       tick_now    = '0;
    mpps_pkg::policy_t sel_policy  = mpps_pkg::POL_FIFO;
    logic [4:0]        job_limit   = mpps_pkg::JOB_COUNT_RST;
    logic [15:0]       slice_len   = mpps_pkg::QUANTUM_RST;

    sched_result_t tick_outcomes_q [$];
    sched_result_t last_outcome = '0;

    int send_idle    = 0;
    int recv_idle    = 0;
    int items_sent   = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    multi_policy_process_scheduler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int choose_job(int n);
        int i;
        int k;
        int best;
        best = -1;
        if (n == 0)
            return -1;
        if (sel_policy == mpps_pkg::POL_FIFO)
        begin
            if (job_busy)
                return int'(cur_job);
            for (i = 0; i < n && tick_now >= arrival_q[i]; i++)
                if (remaining_q[i] != 0)
                    return i;
            return -1;
        end
        if (sel_policy == mpps_pkg::POL_RR)
        begin
            if (job_busy && slice_used < slice_len)
                return int'(cur_job);
            for (i = 0; i < n; i++)
            begin
                k = job_busy ? (int'(cur_job) + 1 + i) % n : i;
                if (remaining_q[k] != 0 && tick_now >= arrival_q[k])
                    return k;
            end
            return -1;
        end
        if (sel_policy == mpps_pkg::POL_SJF && job_busy)
            return int'(cur_job);
        for (i = 0; i < n && tick_now >= arrival_q[i]; i++)
            if (remaining_q[i] != 0 && (best < 0 || remaining_q[best] > remaining_q[i]))
                best = i;
        return best;
    endfunction

    function automatic sched_result_t schedule_tick();
        sched_result_t res;
        int n;
        int nxt;
        int live;
        int i;
        res  = '0;
        live = 0;
        n    = (job_limit > SLOTS) ? SLOTS : int'(job_limit);
        if (job_busy && cur_job >= n)
        begin
            job_busy   = 1'b0;
            slice_used = '0;
        end
        if (job_busy && remaining_q[cur_job] == 0)
        begin
            res.finished_valid = 1'b1;
            res.finished_index = cur_job;
            job_busy   = 1'b0;
            slice_used = '0;
        end
        nxt = choose_job(n);
        if (nxt >= 0 && (!job_busy || nxt != int'(cur_job)))
            res.switched = 1'b1;
        if (slice_used >= slice_len)
            slice_used = '0;
        if (nxt >= 0)
        begin
            cur_job  = nxt[3:0];
            job_busy = 1'b1;
            if (remaining_q[cur_job] != 0)
                remaining_q[cur_job] = remaining_q[cur_job] - 1;
            if (slice_used != mpps_pkg::SLICE_MAX)
                slice_used = slice_used + 1;
        end
        else
            job_busy = 1'b0;
        if (tick_now != mpps_pkg::TIME_MAX)
            tick_now = tick_now + 1;
        for (i = 0; i < n; i++)
            if (remaining_q[i] != 0)
                live++;
        res.running_index = job_busy ? cur_job : 4'd0;
        res.running_valid = job_busy;
        res.all_done      = (live == 0);
        return res;
    endfunction

    function automatic sched_result_t outcome(logic [3:0] ri, logic rv, logic sw, logic fv,
                                              logic [3:0] fi, logic done);
        sched_result_t res;
        res.running_index  = ri;
        res.running_valid  = rv;
        res.switched       = sw;
        res.finished_valid = fv;
        res.finished_index = fi;
        res.all_done       = done;
        return res;
    endfunction

    function automatic plan_row_t cfg_row(mpps_pkg::cfg_index_t r, logic [15:0] w);
        plan_row_t p;
        p         = '0;
        p.kind    = ROW_CFG;
        p.reg_idx = r;
        p.word    = w;
        return p;
    endfunction

    function automatic plan_row_t load_row(logic [3:0] slot, logic [31:0] arrive,
                                           logic [31:0] run);
        plan_row_t p;
        p        = '0;
        p.kind   = ROW_LOAD;
        p.slot   = slot;
        p.arrive = arrive;
        p.run    = run;
        return p;
    endfunction

    function automatic plan_row_t tick_row(logic typed, sched_result_t want);
        plan_row_t p;
        p       = '0;
        p.kind  = ROW_TICK;
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_item(logic mode, logic [3:0] slot, logic [31:0] arrive,
                             logic [31:0] run, logic typed, sched_result_t want);
        sched_result_t forecast;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, run, arrive, slot};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (mode == mpps_pkg::MODE_LOAD)
        begin
            arrival_q[slot]   = arrive;
            remaining_q[slot] = run;
        end
        else
        begin
            forecast     = schedule_tick();
            last_outcome = forecast;
            tick_outcomes_q.push_back(typed ? want : forecast);
        end
    endtask

    task automatic config_write(mpps_pkg::cfg_index_t r, logic [15:0] w);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (r)
            mpps_pkg::CFG_POLICY:    sel_policy = mpps_pkg::policy_t'(w[1:0]);
            mpps_pkg::CFG_JOB_COUNT: job_limit  = w[4:0];
            mpps_pkg::CFG_QUANTUM:   slice_len  = w;
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    // hold off until every tick has reported and the last load has gone through
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tick_outcomes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic tick_once(logic typed, sched_result_t want);
        push_item(mpps_pkg::MODE_TICK, 4'($urandom), $urandom, $urandom, typed, want);
    endtask

    task automatic run_batch();
        logic [15:0] w;
        logic [31:0] at;
        logic [31:0] arrive;
        logic [31:0] run;
        logic [3:0]  slot;
        int roll;
        int n;
        int k;
        int ticks;
        logic broken;
        settle();
        w = 16'($urandom_range(3));
        if ($urandom_range(3) == 0)
            w[15:2] = 14'($urandom);
        if ($urandom_range(3) != 0)
            config_write(mpps_pkg::CFG_POLICY, w);
        roll = $urandom_range(19);
        w = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd16 :
            (roll == 2) ? 16'($urandom_range(17, 31)) : 16'($urandom_range(1, 8));
        if ($urandom_range(3) == 0)
            w[15:5] = 11'($urandom);
        if ($urandom_range(2) != 0)
            config_write(mpps_pkg::CFG_JOB_COUNT, w);
        roll = $urandom_range(19);
        w = (roll == 0) ? 16'd0 : (roll == 1) ? mpps_pkg::SLICE_MAX :
            (roll == 2) ? 16'($urandom) :
            (roll == 3) ? mpps_pkg::QUANTUM_RST : 16'($urandom_range(1, 4));
        if ($urandom_range(2) == 0)
            config_write(mpps_pkg::CFG_QUANTUM, w);

        n      = (job_limit > SLOTS) ? SLOTS : int'(job_limit);
        broken = ($urandom_range(9) == 0);
        at     = tick_now + $urandom_range(2);
        for (k = 0; k < n; k++)
        begin
            if (broken)
            begin
                slot   = 4'($urandom);
                arrive = ($urandom_range(3) == 0) ? $urandom : tick_now + $urandom_range(20);
                run    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8);
            end
            else
            begin
                slot   = k[3:0];
                at     = at + $urandom_range(3);
                arrive = at;
                run    = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 8);
            end
            push_item(mpps_pkg::MODE_LOAD, slot, arrive, run, 1'b0, '0);
        end

        ticks = 0;
        do
        begin
            if ($urandom_range(11) == 0)
                push_item(mpps_pkg::MODE_LOAD, 4'($urandom), tick_now + $urandom_range(3),
                          $urandom_range(6), 1'b0, '0);
            tick_once(1'b0, '0);
            ticks++;
        end
        while (!last_outcome.all_done && ticks < TICK_CAP);
        repeat ($urandom_range(2)) tick_once(1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tick_outcomes_q.size() == 0)
                report_mismatch("result with none pending", 32'(m_tdata), 32'd0);
            else
            begin
                want = tick_outcomes_q.pop_front();
                if (m_tdata[3:0] !== want.running_index)
                    report_mismatch("running_index", 32'(m_tdata[3:0]), 32'(want.running_index));
                if (m_tdata[4] !== want.running_valid)
                    report_mismatch("running_valid", 32'(m_tdata[4]), 32'(want.running_valid));
                if (m_tdata[5] !== want.switched)
                    report_mismatch("switched", 32'(m_tdata[5]), 32'(want.switched));
                if (m_tdata[6] !== want.finished_valid)
                    report_mismatch("finished_valid", 32'(m_tdata[6]),
                                    32'(want.finished_valid));
                if (m_tdata[10:7] !== want.finished_index)
                    report_mismatch("finished_index", 32'(m_tdata[10:7]),
                                    32'(want.finished_index));
                if (m_tdata[11] !== want.all_done)
                    report_mismatch("all_done", 32'(m_tdata[11]), 32'(want.all_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[multi_policy_process_scheduler_top] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_row_t plan [$];
        plan_row_t row;
        int k;
        int ph;
        int phase_end;
        for (k = 0; k < SLOTS; k++)
        begin
            arrival_q[k]   = '0;
            remaining_q[k] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // fill the whole table so that no scan reads an unloaded slot
        for (k = 0; k < SLOTS; k++)
            push_item(mpps_pkg::MODE_LOAD, k[3:0], 32'd0, 32'd0, 1'b0, '0);

        plan = '{
            tick_row(1'b1, outcome(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b1)),
            cfg_row(mpps_pkg::CFG_JOB_COUNT, 16'd0),
            tick_row(1'b1, outcome(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b1)),
            cfg_row(mpps_pkg::CFG_JOB_COUNT, 16'd31),
            load_row(4'd15, 32'd0, '1),
            load_row(4'd0, '1, 32'd1),
            tick_row(1'b1, outcome(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0)),
            cfg_row(mpps_pkg::CFG_POLICY, 16'(mpps_pkg::POL_PSJF)),
            tick_row(1'b1, outcome(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0)),
            cfg_row(mpps_pkg::CFG_POLICY, 16'(mpps_pkg::POL_RR)),
            cfg_row(mpps_pkg::CFG_QUANTUM, 16'd0),
            tick_row(1'b1, outcome(4'd15, 1'b1, 1'b1, 1'b0, 4'd0, 1'b0)),
            tick_row(1'b0, '0),
            load_row(4'd15, 32'd0, 32'd0),
            tick_row(1'b1, outcome(4'd0, 1'b0, 1'b0, 1'b1, 4'd15, 1'b0)),
            load_row(4'd0, 32'd0, 32'd2),
            cfg_row(mpps_pkg::CFG_QUANTUM, mpps_pkg::SLICE_MAX),
            cfg_row(mpps_pkg::CFG_POLICY, 16'(mpps_pkg::POL_SJF)),
            load_row(4'd3, 32'd1, 32'd1),
            tick_row(1'b0, '0),
            tick_row(1'b0, '0),
            cfg_row(mpps_pkg::CFG_POLICY, 16'(mpps_pkg::POL_FIFO)),
            tick_row(1'b0, '0),
            tick_row(1'b0, '0),
            tick_row(1'b0, '0),
            cfg_row(mpps_pkg::CFG_JOB_COUNT, 16'd1),
            tick_row(1'b0, '0)
        };

        foreach (plan[p])
        begin
            row = plan[p];
            case (row.kind)
                ROW_CFG:
                begin
                    settle();
                    config_write(row.reg_idx, row.word);
                end
                ROW_LOAD: push_item(mpps_pkg::MODE_LOAD, row.slot, row.arrive, row.run,
                                    1'b0, '0);
                default:  tick_once(row.typed, row.want);
            endcase
        end

        for (ph = 0; ph < 4; ph++)
        begin
            settle();
            send_idle = (ph == 1) ? 82 : (ph == 3) ? 35 : 0;
            recv_idle = (ph == 2) ? 82 : (ph == 3) ? 35 : 0;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_batch();
        end

        settle();
        if (mismatches == 0 && tick_outcomes_q.size() == 0)
            $display("[multi_policy_process_scheduler_top] OK");
        else
            $display("[multi_policy_process_scheduler_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mpps_pkg.sv
hw/rtl/mpps_ram.sv
hw/rtl/mpps_scan.sv
hw/rtl/multi_policy_process_scheduler_top.sv
test/testbench.sv
